[rtl/core/closest_ray_segment_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers for the closest ray/segment core.
// ----------------------------------------------------------------------------
`ifndef CLOSEST_RAY_SEGMENT_CORE_ASSERT_SVH
`define CLOSEST_RAY_SEGMENT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property holds at every edge out of reset
`define CRS_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRS_ASSERT(lbl, clk, rstn, prop, msg)
`define CRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/core/crs_pkg.sv]
// ----------------------------------------------------------------------------
// crs_pkg
// Types, widths and constants of the closest ray/segment core.
// ----------------------------------------------------------------------------
package crs_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;

	localparam int DIFW  = COORD_WIDTH + 1;
	localparam int PRW   = 2 * DIFW;
	localparam int DOTW  = PRW + 2;
	localparam int FLW   = DOTW - FRAC_BITS;
	localparam int MW    = 2 * FLW;
	localparam int NW    = MW + 1;
	localparam int DIVN  = NW + FRAC_BITS;
	localparam int QB    = COORD_WIDTH;
	localparam int RAYW  = COORD_WIDTH - 1;
	localparam int SEGW  = FRAC_BITS + 1;
	localparam int DISTW = 63;
	localparam int SDW   = 2 * COORD_WIDTH;
	localparam int TEW   = SEGW + 1 + DIFW;
	localparam int PW    = 2 * COORD_WIDTH - FRAC_BITS + 1;
	localparam int PSW   = DIFW + 3;
	localparam int DFW   = ((PW > PSW) ? PW : PSW) + 1;
	localparam int SQW   = 2 * DFW;
	localparam int SUMW  = SQW + 2;

	localparam logic [RAYW-1:0]  RAY_MAX  = '1;
	localparam logic [SEGW-1:0]  SEG_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DISTW-1:0] DIST_MAX = '1;

	localparam int DOT_DD = 0;
	localparam int DOT_DE = 1;
	localparam int DOT_EE = 2;
	localparam int DOT_DR = 3;
	localparam int DOT_ER = 4;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFW-1:0]        diff_t;
	typedef logic signed [PRW-1:0]         prod_t;
	typedef logic signed [DOTW-1:0]        dot_t;
	typedef logic signed [DFW-1:0]         wpt_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		coord_t seg_a_x;
		coord_t seg_a_y;
		coord_t seg_a_z;
		coord_t seg_b_x;
		coord_t seg_b_y;
		coord_t seg_b_z;
	} req_t;

	typedef struct packed {
		logic [DISTW-1:0] dist_sq;
		logic [RAYW-1:0]  ray_param;
		logic [SEGW-1:0]  seg_param;
		coord_t           ray_pt_x;
		coord_t           ray_pt_y;
		coord_t           ray_pt_z;
		coord_t           seg_pt_x;
		coord_t           seg_pt_y;
		coord_t           seg_pt_z;
	} rsp_t;

	typedef struct packed {
		coord_t [2:0] o;
		coord_t [2:0] d;
		coord_t [2:0] a;
		diff_t  [2:0] e;
		logic         degen;
	} geom_t;

	typedef struct packed {
		logic            ok;
		logic [RAYW-1:0] s;
		logic [SEGW-1:0] t;
	} cand_t;

	typedef struct packed {
		cand_t      [3:0]      c;
		wpt_t       [3:0][2:0] pr;
		wpt_t       [3:0][2:0] ps;
	} cpts_t;

	function automatic coord_t sat_coord(wpt_t v);
		coord_t r;
		if (v > wpt_t'(coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}}))) begin
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end else if (v < wpt_t'(coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}}))) begin
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			r = v[COORD_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

[rtl/core/crs_delay.sv]
// ----------------------------------------------------------------------------
// crs_delay
// Enabled register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module crs_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] dly_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign dout = dly_q[DEPTH-1];

endmodule

[rtl/core/crs_mul.sv]
// ----------------------------------------------------------------------------
// crs_mul
// Three-stage signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module crs_mul #(
	parameter int W = 52
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);

	localparam int LO  = (W + 1) / 2;
	localparam int HI  = W - LO;
	localparam int PW2 = 2 * W;

	logic [W-1:0]     ma_s1, mb_s1;
	logic             ng_s1, ng_s2;
	logic [2*LO-1:0]  pll_s2;
	logic [LO+HI-1:0] plh_s2, phl_s2;
	logic [2*HI-1:0]  phh_s2;
	logic [PW2-1:0]   acc;
	logic [PW2-1:0]   p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ng_s1  <= a[W-1] ^ b[W-1];
			ma_s1  <= a[W-1] ? $unsigned(-a) : $unsigned(a);
			mb_s1  <= b[W-1] ? $unsigned(-b) : $unsigned(b);
			ng_s2  <= ng_s1;
			pll_s2 <= ma_s1[LO-1:0] * mb_s1[LO-1:0];
			plh_s2 <= ma_s1[LO-1:0] * mb_s1[W-1:LO];
			phl_s2 <= ma_s1[W-1:LO] * mb_s1[LO-1:0];
			phh_s2 <= ma_s1[W-1:LO] * mb_s1[W-1:LO];
			p_s3   <= ng_s2 ? (~acc + PW2'(1)) : acc;
		end
	end

	always_comb begin
		acc = PW2'(pll_s2) + ((PW2'(plh_s2) + PW2'(phl_s2)) << LO)
			+ (PW2'(phh_s2) << (2 * LO));
	end

	assign p = $signed(p_s3);

endmodule

[rtl/core/crs_div.sv]
// ----------------------------------------------------------------------------
// crs_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module crs_div #(
	parameter int NW = 121,
	parameter int DW = 105,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          zero,
	output logic [QW-1:0] quo,
	output logic          ovf,
	output logic          zr
);

	localparam int CMPW = ((NW > DW) ? NW : DW) + QW;

	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] q_s   [QW+1];
	logic          ovf_s [QW+1];
	logic          zr_s  [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
			zr_s[0]  <= zero;
			ovf_s[0] <= CMPW'(num) >= (CMPW'(den) << QW);
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int B = QW - 1 - i;
		logic [CMPW-1:0] sh, dif;
		logic            ge;
		logic [QW-1:0]   qn;

		always_comb begin
			sh  = CMPW'(den_s[i]) << B;
			ge  = CMPW'(rem_s[i]) >= sh;
			dif = CMPW'(rem_s[i]) - sh;
			qn  = q_s[i];
			qn[B] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? dif[NW-1:0] : rem_s[i];
				den_s[i+1] <= den_s[i];
				q_s[i+1]   <= qn;
				zr_s[i+1]  <= zr_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quo = q_s[QW];
	assign ovf = ovf_s[QW];
	assign zr  = zr_s[QW];

endmodule

[rtl/core/closest_ray_segment_core.sv]
// ----------------------------------------------------------------------------
// closest_ray_segment_core
// Closest points between a 3D ray and a segment, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) takes one query item: ray origin,
//   ray direction and both segment endpoints, signed Q16.16.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one item per query: squared
//   distance, both parameters and both closest points, in query order.
//   One item is accepted every cycle while rsp is taken; the pipeline depth is
//   set by the 32 stages of the restoring dividers (one quotient bit each),
//   plus the dot product stages, the split wide multipliers and the candidate
//   distance stages.
//   Reset (arst_n low) empties the pipeline; no item is in flight after it.
//   When the receiver holds rsp_ready low with a result waiting, the whole
//   pipeline holds and req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "closest_ray_segment_core_assert.svh"

module closest_ray_segment_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  crs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output crs_pkg::rsp_t rsp
);

	localparam int FB    = crs_pkg::FRAC_BITS;
	localparam int DIFW  = crs_pkg::DIFW;
	localparam int DOTW  = crs_pkg::DOTW;
	localparam int FLW   = crs_pkg::FLW;
	localparam int MW    = crs_pkg::MW;
	localparam int NW    = crs_pkg::NW;
	localparam int DIVN  = crs_pkg::DIVN;
	localparam int QB    = crs_pkg::QB;
	localparam int RAYW  = crs_pkg::RAYW;
	localparam int SEGW  = crs_pkg::SEGW;
	localparam int DISTW = crs_pkg::DISTW;
	localparam int SDW   = crs_pkg::SDW;
	localparam int TEW   = crs_pkg::TEW;
	localparam int DFW   = crs_pkg::DFW;
	localparam int SQW   = crs_pkg::SQW;
	localparam int SUMW  = crs_pkg::SUMW;
	localparam int NSTG  = QB + 16;
	localparam int GEOW  = $bits(crs_pkg::geom_t);
	localparam int CPTW  = $bits(crs_pkg::cpts_t);

	logic            en;
	logic [NSTG:1]   vld_q;

	assign en        = !vld_q[NSTG] || rsp_ready;
	assign req_ready = en;
	assign rsp_valid = vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-1:1], req_valid};
		end
	end

	// input register
	crs_pkg::req_t req_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1 <= req;
		end
	end

	// differences E = B - A, R = O - A
	crs_pkg::coord_t [2:0] o1, d1, a1, b1;
	crs_pkg::geom_t        geo_s2;
	crs_pkg::diff_t  [2:0] r_s2;

	always_comb begin
		o1 = {req_s1.origin_z, req_s1.origin_y, req_s1.origin_x};
		d1 = {req_s1.dir_z, req_s1.dir_y, req_s1.dir_x};
		a1 = {req_s1.seg_a_z, req_s1.seg_a_y, req_s1.seg_a_x};
		b1 = {req_s1.seg_b_z, req_s1.seg_b_y, req_s1.seg_b_x};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2.o     <= o1;
			geo_s2.d     <= d1;
			geo_s2.a     <= a1;
			geo_s2.degen <= (a1 == b1);
			for (int i = 0; i < 3; i++) begin
				geo_s2.e[i] <= DIFW'($signed(b1[i])) - DIFW'($signed(a1[i]));
				r_s2[i]     <= DIFW'($signed(o1[i])) - DIFW'($signed(a1[i]));
			end
		end
	end

	// exact products
	crs_pkg::prod_t [4:0][2:0] prd_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prd_s3[crs_pkg::DOT_DD][i] <= DIFW'($signed(geo_s2.d[i])) *
					DIFW'($signed(geo_s2.d[i]));
				prd_s3[crs_pkg::DOT_DE][i] <= DIFW'($signed(geo_s2.d[i])) *
					$signed(geo_s2.e[i]);
				prd_s3[crs_pkg::DOT_EE][i] <= $signed(geo_s2.e[i]) * $signed(geo_s2.e[i]);
				prd_s3[crs_pkg::DOT_DR][i] <= DIFW'($signed(geo_s2.d[i])) *
					$signed(r_s2[i]);
				prd_s3[crs_pkg::DOT_ER][i] <= $signed(geo_s2.e[i]) * $signed(r_s2[i]);
			end
		end
	end

	// dot sums
	crs_pkg::dot_t [4:0] dot_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 5; k++) begin
				dot_s4[k] <= DOTW'($signed(prd_s3[k][0])) + DOTW'($signed(prd_s3[k][1]))
					+ DOTW'($signed(prd_s3[k][2]));
			end
		end
	end

	// floored dots into six wide multipliers
	logic signed [FLW-1:0] fdd, fde, fee, fdr, fer;
	logic signed [FLW-1:0] mul_a [6];
	logic signed [FLW-1:0] mul_b [6];
	logic signed [MW-1:0]  mul_p [6];

	always_comb begin
		fdd = dot_s4[crs_pkg::DOT_DD][DOTW-1:FB];
		fde = dot_s4[crs_pkg::DOT_DE][DOTW-1:FB];
		fee = dot_s4[crs_pkg::DOT_EE][DOTW-1:FB];
		fdr = dot_s4[crs_pkg::DOT_DR][DOTW-1:FB];
		fer = dot_s4[crs_pkg::DOT_ER][DOTW-1:FB];
		mul_a[0] = fdd; mul_b[0] = fee;
		mul_a[1] = fde; mul_b[1] = fde;
		mul_a[2] = fde; mul_b[2] = fer;
		mul_a[3] = fee; mul_b[3] = fdr;
		mul_a[4] = fdd; mul_b[4] = fer;
		mul_a[5] = fde; mul_b[5] = fdr;
	end

	for (genvar m = 0; m < 6; m++) begin : g_mdet
		crs_mul #(.W(FLW)) u_mul (
			.clk(clk), .en(en), .a(mul_a[m]), .b(mul_b[m]), .p(mul_p[m])
		);
	end

	logic [5*DOTW-1:0]     dotd;
	crs_pkg::dot_t [4:0]   dot_s8;
	crs_delay #(.W(5*DOTW), .DEPTH(4)) u_dly_dot (
		.clk(clk), .en(en), .din(dot_s4), .dout(dotd)
	);
	assign dot_s8 = dotd;

	logic signed [NW-1:0] det_s8, ns_s8, nt_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			det_s8 <= NW'(mul_p[0]) - NW'(mul_p[1]);
			ns_s8  <= NW'(mul_p[2]) - NW'(mul_p[3]);
			nt_s8  <= NW'(mul_p[4]) - NW'(mul_p[5]);
		end
	end

	// divider operands
	logic                  detpos;
	crs_pkg::dot_t         pa_num, pb_num, po_num, dd8, ee8;
	logic [DIVN-1:0]       dv_n [5];
	logic [NW-1:0]         dv_d [5];
	logic                  dv_z [5];
	logic [QB-1:0]         dv_q [5];
	logic                  dv_o [5];
	logic                  dv_zr [5];

	always_comb begin
		detpos = !det_s8[NW-1] && (det_s8 != '0);
		dd8    = dot_s8[crs_pkg::DOT_DD];
		ee8    = dot_s8[crs_pkg::DOT_EE];
		pa_num = -dot_s8[crs_pkg::DOT_DR];
		pb_num = dot_s8[crs_pkg::DOT_DE] - dot_s8[crs_pkg::DOT_DR];
		po_num = dot_s8[crs_pkg::DOT_ER];
		dv_n[0] = DIVN'($unsigned(ns_s8)) << FB;
		dv_d[0] = $unsigned(det_s8);
		dv_z[0] = !detpos || ns_s8[NW-1] || (ns_s8 == '0);
		dv_n[1] = DIVN'($unsigned(nt_s8)) << FB;
		dv_d[1] = $unsigned(det_s8);
		dv_z[1] = !detpos || nt_s8[NW-1] || (nt_s8 == '0);
		dv_n[2] = DIVN'($unsigned(pa_num)) << FB;
		dv_d[2] = NW'($unsigned(dd8));
		dv_z[2] = (dd8 == '0) || pa_num[DOTW-1] || (pa_num == '0);
		dv_n[3] = DIVN'($unsigned(pb_num)) << FB;
		dv_d[3] = NW'($unsigned(dd8));
		dv_z[3] = (dd8 == '0) || pb_num[DOTW-1] || (pb_num == '0);
		dv_n[4] = DIVN'($unsigned(po_num)) << FB;
		dv_d[4] = NW'($unsigned(ee8));
		dv_z[4] = (ee8 == '0) || po_num[DOTW-1] || (po_num == '0);
	end

	for (genvar k = 0; k < 5; k++) begin : g_div
		crs_div #(.NW(DIVN), .DW(NW), .QW(QB)) u_div (
			.clk(clk), .en(en), .num(dv_n[k]), .den(dv_d[k]), .zero(dv_z[k]),
			.quo(dv_q[k]), .ovf(dv_o[k]), .zr(dv_zr[k])
		);
	end

	logic           detpos_d;
	logic [GEOW-1:0] geod;
	crs_pkg::geom_t  geo_d;
	crs_delay #(.W(1), .DEPTH(QB + 1)) u_dly_det (
		.clk(clk), .en(en), .din(detpos), .dout(detpos_d)
	);
	crs_delay #(.W(GEOW), .DEPTH(QB + 7)) u_dly_geo (
		.clk(clk), .en(en), .din(geo_s2), .dout(geod)
	);
	assign geo_d = geod;

	// candidate parameters and their point products
	logic [RAYW-1:0] sq_ray [5];
	logic [SEGW-1:0] sq_seg [5];
	crs_pkg::cand_t [3:0] cnd;

	always_comb begin
		for (int k = 0; k < 5; k++) begin
			if (dv_zr[k]) begin
				sq_ray[k] = '0;
				sq_seg[k] = '0;
			end else begin
				sq_ray[k] = (dv_o[k] || dv_q[k] > QB'(crs_pkg::RAY_MAX)) ?
					crs_pkg::RAY_MAX : dv_q[k][RAYW-1:0];
				sq_seg[k] = (dv_o[k] || dv_q[k] > QB'(crs_pkg::SEG_ONE)) ?
					crs_pkg::SEG_ONE : dv_q[k][SEGW-1:0];
			end
		end
		cnd[0] = '{ok: detpos_d && !geo_d.degen, s: sq_ray[0], t: sq_seg[1]};
		cnd[1] = '{ok: 1'b1, s: sq_ray[2], t: '0};
		cnd[2] = '{ok: !geo_d.degen, s: sq_ray[3], t: crs_pkg::SEG_ONE};
		cnd[3] = '{ok: !geo_d.degen, s: '0, t: sq_seg[4]};
	end

	crs_pkg::cand_t [3:0]   cnd_s42;
	crs_pkg::geom_t         geo_s42;
	logic signed [SDW-1:0]  sd_s42 [4][3];
	logic signed [TEW-1:0]  te_s42 [4][3];

	always_ff @(posedge clk) begin
		if (en) begin
			cnd_s42 <= cnd;
			geo_s42 <= geo_d;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					sd_s42[k][i] <= $signed({1'b0, cnd[k].s}) * $signed(geo_d.d[i]);
					te_s42[k][i] <= $signed({1'b0, cnd[k].t}) * $signed(geo_d.e[i]);
				end
			end
		end
	end

	// points and differences
	crs_pkg::cpts_t cpt_s43;
	crs_pkg::wpt_t  df_s43 [4][3];

	always_ff @(posedge clk) begin
		if (en) begin
			cpt_s43.c <= cnd_s42;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					cpt_s43.pr[k][i] <= DFW'($signed(geo_s42.o[i])) + DFW'(sd_s42[k][i] >>> FB);
					cpt_s43.ps[k][i] <= DFW'($signed(geo_s42.a[i])) + DFW'(te_s42[k][i] >>> FB);
					df_s43[k][i] <= (DFW'($signed(geo_s42.o[i])) + DFW'(sd_s42[k][i] >>> FB))
						- (DFW'($signed(geo_s42.a[i])) + DFW'(te_s42[k][i] >>> FB));
				end
			end
		end
	end

	logic signed [SQW-1:0] sq [4][3];
	for (genvar k = 0; k < 4; k++) begin : g_cand
		for (genvar i = 0; i < 3; i++) begin : g_axis
			crs_mul #(.W(DFW)) u_sq (
				.clk(clk), .en(en), .a(df_s43[k][i]), .b(df_s43[k][i]), .p(sq[k][i])
			);
		end
	end

	logic [CPTW-1:0] cptd;
	crs_pkg::cpts_t  cpt_s47;
	crs_delay #(.W(CPTW), .DEPTH(4)) u_dly_cpt (
		.clk(clk), .en(en), .din(cpt_s43), .dout(cptd)
	);
	assign cpt_s47 = cptd;

	// distances, saturated
	logic [SUMW-1:0]  sum [4];
	logic [DISTW-1:0] dist_s47 [4];

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum[k] = SUMW'($unsigned(sq[k][0])) + SUMW'($unsigned(sq[k][1]))
				+ SUMW'($unsigned(sq[k][2]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				dist_s47[k] <= (sum[k] > SUMW'(crs_pkg::DIST_MAX)) ?
					crs_pkg::DIST_MAX : sum[k][DISTW-1:0];
			end
		end
	end

	// first strictly smallest candidate
	crs_pkg::rsp_t    rsp_s48;
	logic             have;
	logic [DISTW-1:0] bdist;
	logic [1:0]       bsel;

	always_comb begin
		have  = 1'b0;
		bdist = '0;
		bsel  = '0;
		for (int k = 0; k < 4; k++) begin
			if (cpt_s47.c[k].ok && (!have || dist_s47[k] < bdist)) begin
				have  = 1'b1;
				bdist = dist_s47[k];
				bsel  = 2'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_s48.dist_sq   <= bdist;
			rsp_s48.ray_param <= cpt_s47.c[bsel].s;
			rsp_s48.seg_param <= cpt_s47.c[bsel].t;
			rsp_s48.ray_pt_x  <= crs_pkg::sat_coord(cpt_s47.pr[bsel][0]);
			rsp_s48.ray_pt_y  <= crs_pkg::sat_coord(cpt_s47.pr[bsel][1]);
			rsp_s48.ray_pt_z  <= crs_pkg::sat_coord(cpt_s47.pr[bsel][2]);
			rsp_s48.seg_pt_x  <= crs_pkg::sat_coord(cpt_s47.ps[bsel][0]);
			rsp_s48.seg_pt_y  <= crs_pkg::sat_coord(cpt_s47.ps[bsel][1]);
			rsp_s48.seg_pt_z  <= crs_pkg::sat_coord(cpt_s47.ps[bsel][2]);
		end
	end

	assign rsp = rsp_s48;

	`CRS_ASSERT(a_seg_range, clk, arst_n, !rsp_valid || rsp.seg_param <= crs_pkg::SEG_ONE, "seg_param above one")
	`CRS_ASSERT_NEXT(a_stall_hold, clk, arst_n, rsp_valid && !rsp_ready, $countones(vld_q) == $past($countones(vld_q)), "item count changed during stall")
	`CRS_ASSERT_NEXT(a_enter, clk, arst_n, req_valid && req_ready, vld_q[1], "accepted item not in first stage")

endmodule

[tb/closest_ray_segment_core_test.sv]
// ----------------------------------------------------------------------------
// closest_ray_segment_core_test
// Streams ray/segment queries through the core with random gaps on both sides
// and one long output stall, and checks every result item against an
// exact-integer prediction of the closest points.
// ----------------------------------------------------------------------------
module closest_ray_segment_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] big_t;

	localparam longint RAY_CAP  = 64'h7FFF_FFFF;
	localparam longint SEG_CAP  = 64'h1_0000;
	localparam big_t   DIST_CAP = big_t'(64'h7FFF_FFFF_FFFF_FFFF);
	localparam int     N_RANDOM = 850;

	class closest_pair_board;
		crs_pkg::rsp_t want_q[$];
		int   errors;

		function longint flr(longint x);
			return x >>> crs_pkg::FRAC_BITS;
		endfunction

		function big_t dot(longint x[3], longint y[3]);
			big_t s;
			s = 0;
			for (int i = 0; i < 3; i++) s += big_t'(x[i]) * big_t'(y[i]);
			return s;
		endfunction

		function longint quot(big_t num, big_t den, longint cap);
			big_t q;
			if (den == 0 || num <= 0) return 0;
			q = (num <<< crs_pkg::FRAC_BITS) / den;
			return (q > big_t'(cap)) ? cap : longint'(q);
		endfunction

		function longint proj(longint p[3], longint q[3], longint v[3], longint cap);
			longint df[3];
			for (int i = 0; i < 3; i++) df[i] = p[i] - q[i];
			return quot(dot(df, v), dot(v, v), cap);
		endfunction

		function crs_pkg::coord_t clip(longint v);
			if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'h8000_0000;
			return v[31:0];
		endfunction

		function void try_pair(longint o[3], longint d[3], longint a[3], longint e[3],
			longint s, longint t, inout bit have, inout crs_pkg::rsp_t best);
			longint pr[3], ps[3], df[3];
			big_t sum;
			logic [62:0] cur_dsq;
			for (int i = 0; i < 3; i++) begin
				pr[i] = o[i] + flr(s * d[i]);
				ps[i] = a[i] + flr(t * e[i]);
				df[i] = pr[i] - ps[i];
			end
			sum = dot(df, df);
			cur_dsq = (sum > DIST_CAP) ? DIST_CAP[62:0] : sum[62:0];
			if (!have || cur_dsq < best.dist_sq) begin
				have = 1;
				best.dist_sq = cur_dsq;
				best.ray_param = s[crs_pkg::RAYW-1:0];
				best.seg_param = t[crs_pkg::SEGW-1:0];
				best.ray_pt_x = clip(pr[0]);
				best.ray_pt_y = clip(pr[1]);
				best.ray_pt_z = clip(pr[2]);
				best.seg_pt_x = clip(ps[0]);
				best.seg_pt_y = clip(ps[1]);
				best.seg_pt_z = clip(ps[2]);
			end
		endfunction

		function void note(crs_pkg::req_t q);
			longint o[3], d[3], a[3], b[3], e[3], r[3];
			longint dd, de, ee, dr, er, s, t;
			big_t det;
			bit have;
			crs_pkg::rsp_t best;
			o = '{q.origin_x, q.origin_y, q.origin_z};
			d = '{q.dir_x, q.dir_y, q.dir_z};
			a = '{q.seg_a_x, q.seg_a_y, q.seg_a_z};
			b = '{q.seg_b_x, q.seg_b_y, q.seg_b_z};
			for (int i = 0; i < 3; i++) begin
				e[i] = b[i] - a[i];
				r[i] = o[i] - a[i];
			end
			have = 0;
			best = '0;
			if (e[0] == 0 && e[1] == 0 && e[2] == 0) begin
				try_pair(o, d, a, e, proj(a, o, d, RAY_CAP), 0, have, best);
			end else begin
				dd = longint'(dot(d, d) >>> crs_pkg::FRAC_BITS);
				de = longint'(dot(d, e) >>> crs_pkg::FRAC_BITS);
				ee = longint'(dot(e, e) >>> crs_pkg::FRAC_BITS);
				dr = longint'(dot(d, r) >>> crs_pkg::FRAC_BITS);
				er = longint'(dot(e, r) >>> crs_pkg::FRAC_BITS);
				det = big_t'(dd) * big_t'(ee) - big_t'(de) * big_t'(de);
				if (det > 0) begin
					s = quot(big_t'(de) * big_t'(er) - big_t'(ee) * big_t'(dr), det, RAY_CAP);
					t = quot(big_t'(dd) * big_t'(er) - big_t'(de) * big_t'(dr), det, SEG_CAP);
					try_pair(o, d, a, e, s, t, have, best);
				end
				try_pair(o, d, a, e, proj(a, o, d, RAY_CAP), 0, have, best);
				try_pair(o, d, a, e, proj(b, o, d, RAY_CAP), SEG_CAP, have, best);
				try_pair(o, d, a, e, 0, proj(o, a, e, SEG_CAP), have, best);
			end
			want_q.push_back(best);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		task check(crs_pkg::rsp_t got);
			crs_pkg::rsp_t w;
			if (want_q.size() == 0) begin
				report("unexpected item", 64'(got.dist_sq), 0);
				return;
			end
			w = want_q.pop_front();
			if (got.dist_sq !== w.dist_sq) report("dist_sq", 64'(got.dist_sq), 64'(w.dist_sq));
			if (got.ray_param !== w.ray_param)
				report("ray_param", 64'(got.ray_param), 64'(w.ray_param));
			if (got.seg_param !== w.seg_param)
				report("seg_param", 64'(got.seg_param), 64'(w.seg_param));
			if (got.ray_pt_x !== w.ray_pt_x) report("ray_pt_x", 64'(got.ray_pt_x), 64'(w.ray_pt_x));
			if (got.ray_pt_y !== w.ray_pt_y) report("ray_pt_y", 64'(got.ray_pt_y), 64'(w.ray_pt_y));
			if (got.ray_pt_z !== w.ray_pt_z) report("ray_pt_z", 64'(got.ray_pt_z), 64'(w.ray_pt_z));
			if (got.seg_pt_x !== w.seg_pt_x) report("seg_pt_x", 64'(got.seg_pt_x), 64'(w.seg_pt_x));
			if (got.seg_pt_y !== w.seg_pt_y) report("seg_pt_y", 64'(got.seg_pt_y), 64'(w.seg_pt_y));
			if (got.seg_pt_z !== w.seg_pt_z) report("seg_pt_z", 64'(got.seg_pt_z), 64'(w.seg_pt_z));
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0;
	logic req_ready;
	crs_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	crs_pkg::rsp_t rsp;

	closest_pair_board board = new();
	int  n_taken = 0;
	bit  stall_done = 0;
	crs_pkg::req_t plan_q[$];

	closest_ray_segment_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			board.note(req);
			n_taken++;
		end
		if (arst_n && rsp_valid && rsp_ready) board.check(rsp);
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic crs_pkg::coord_t rnd_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom);
			3: return 32'($urandom);
			4: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
			default: return 32'($signed($urandom_range(0, 32'h00C8_0000)) - 32'sh0064_0000);
		endcase
	endfunction

	function automatic crs_pkg::req_t rnd_query();
		crs_pkg::req_t q;
		int k;
		q = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
			rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
		k = $urandom_range(0, 19);
		if (k == 0) begin
			q.seg_b_x = q.seg_a_x;
			q.seg_b_y = q.seg_a_y;
			q.seg_b_z = q.seg_a_z;
		end else if (k == 1) begin
			q.dir_x = 0;
			q.dir_y = 0;
			q.dir_z = 0;
		end else if (k == 2) begin
			// segment parallel to the ray
			q.seg_b_x = q.seg_a_x + q.dir_x;
			q.seg_b_y = q.seg_a_y + q.dir_y;
			q.seg_b_z = q.seg_a_z + q.dir_z;
		end else if (k == 3) begin
			q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end
		return q;
	endfunction

	task automatic directed_set();
		crs_pkg::req_t q;
		plan_q.push_back('0);
		plan_q.push_back({12{32'h7FFF_FFFF}});
		plan_q.push_back({12{32'h8000_0000}});
		plan_q.push_back({12{32'hFFFF_FFFF}});
		// crossing lines: interior solution
		plan_q.push_back({32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
			32'h5_0000, -32'sh3_0000, 32'h2_0000, 32'h5_0000, 32'h3_0000, 32'h2_0000});
		// degenerate segment
		plan_q.push_back({32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h0, 32'h1_0000, 32'h0,
			32'h4_0000, 32'h9_0000, -32'sh2_0000, 32'h4_0000, 32'h9_0000, -32'sh2_0000});
		// zero direction
		plan_q.push_back({32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h0,
			32'h0, 32'h0, 32'h0, 32'h4_0000, 32'h0, 32'h0});
		// parallel
		plan_q.push_back({32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
			32'h0, 32'h2_0000, 32'h0, 32'h3_0000, 32'h2_0000, 32'h0});
		// tiny direction, far segment: ray parameter saturates
		plan_q.push_back({32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0,
			32'h7FFF_0000, 32'h0, 32'h0, 32'h7FFF_0000, 32'h1_0000, 32'h0});
		// huge distance, points at the range edges
		plan_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0});
		q = {32'h7FFF_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
			32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h1};
		plan_q.push_back(q);
		// segment behind the origin
		plan_q.push_back({32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0,
			-32'sh5_0000, 32'h1_0000, 32'h0, -32'sh5_0000, -32'sh1_0000, 32'h0});
		for (int i = 0; i < 6; i++) begin
			q = '0;
			q.dir_x = 32'h8000_0000 >> i;
			q.seg_a_y = 32'h7FFF_FFFF;
			q.seg_b_y = 32'h8000_0000;
			q.seg_b_x = 32'($urandom);
			plan_q.push_back(q);
		end
	endtask

	initial begin
		crs_pkg::req_t q;
		int g;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_set();
		for (int i = 0; i < N_RANDOM; i++) plan_q.push_back(rnd_query());
		while (plan_q.size() > 0) begin
			q = plan_q.pop_front();
			g = gap_len();
			if (g > 0) begin
				req_valid <= 0;
				repeat (g) @(posedge clk);
			end
			req_valid <= 1;
			req <= q;
			do @(posedge clk); while (!req_ready);
		end
		req_valid <= 0;
		@(posedge clk);
		while (board.want_q.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0)
			$display("closest_ray_segment_core test passed");
		else
			$display("closest_ray_segment_core test failed");
		$finish;
	end

	// output side: random holds plus one long hold so the pipe backs up
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stall_done && n_taken >= 300) begin
				stall_done = 1;
				rsp_ready <= 0;
				repeat (150) @(posedge clk);
			end
			g = gap_len();
			if (g > 0) begin
				rsp_ready <= 0;
				repeat (g) @(posedge clk);
			end
			rsp_ready <= 1;
			repeat ($urandom_range(0, 6)) @(posedge clk);
		end
	end

	initial begin
		#20ms;
		$display("closest_ray_segment_core test failed");
		$finish;
	end
endmodule
